// ===== sv/lcd_window_and_bitmap_pixel_writer_top_assert.svh =====
// Assertion macros for the pixel writer RTL.
// Each module that asserts includes this file; it expects clk and rst in scope.
`ifndef LCD_WINDOW_AND_BITMAP_PIXEL_WRITER_TOP_ASSERT_SVH
`define LCD_WINDOW_AND_BITMAP_PIXEL_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define LWBP_ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define LWBP_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define LWBP_ASSERT_HOLDS(name, cond, msg)
`define LWBP_ASSERT_IMPLIES(name, ante, cons, msg)

`endif

`endif

// ===== sv/lwbp_pkg.sv =====
// Package for the LCD window and bitmap pixel writer: codes, types, helpers.
// Used by every module of the block; depends on nothing.
package lwbp_pkg;

  // Coordinate width sent to the display (8..16)
  localparam int COORD_BITS = 9;
  localparam int COORD_MASK = (1 << COORD_BITS) - 1;

  // Job queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input command codes
  localparam logic [1:0] CMD_BEGIN_WINDOW = 2'd0;
  localparam logic [1:0] CMD_BITMAP_BYTE  = 2'd1;
  localparam logic [1:0] CMD_DIRECT_PIXEL = 2'd2;

  // Display controller command bytes
  localparam logic [7:0] LCD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] LCD_ROW_SET      = 8'h2B;
  localparam logic [7:0] LCD_MEMORY_WRITE = 8'h2C;

  // Bytes in a window setup sequence, as last step index
  localparam logic [3:0] WINDOW_LAST_STEP = 4'd10;
  localparam logic [3:0] PIXEL_LAST_STEP  = 4'd1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd0;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_STRIDE  = 3'd2;
  localparam logic [2:0] REG_FIRST_BIT   = 3'd3;
  localparam logic [2:0] REG_COLOR_ZERO  = 3'd4;
  localparam logic [2:0] REG_COLOR_ONE   = 3'd5;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    JOB_WINDOW,
    JOB_BITMAP,
    JOB_PIXEL
  } job_kind_t;

  // One unit of work for the byte sequencer
  typedef struct packed {
    job_kind_t   kind;
    coord_t      xs;
    coord_t      xe;
    coord_t      ys;
    coord_t      ye;
    logic [15:0] value;      // bitmap byte in [7:0], or pixel color
    logic [2:0]  first_bit;  // first bit, from the MSB, of a bitmap byte
    logic [3:0]  last_step;  // index of the final output byte
  } job_t;

  // Configuration registers
  typedef struct packed {
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [7:0]  row_stride_bytes;
    logic [2:0]  first_bit_offset;
    logic [15:0] color_for_zero;
    logic [15:0] color_for_one;
  } cfg_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

  // Start coordinate, wrapped to the coordinate width
  function automatic coord_t coord_start(input logic [8:0] origin);
    logic [17:0] ext;
    ext = {9'd0, origin};
    return ext[COORD_BITS-1:0];
  endfunction

  // End coordinate: origin + size - 1, wrapped
  function automatic coord_t coord_end(input logic [8:0] origin, input logic [9:0] size);
    logic [17:0] sum;
    sum = {9'd0, origin} + {8'd0, size} + 18'(COORD_MASK);
    return sum[COORD_BITS-1:0];
  endfunction

  // High byte of a coordinate
  function automatic logic [7:0] coord_hi(input coord_t c);
    logic [15:0] w;
    w = 16'(c);
    return w[15:8];
  endfunction

  // Low byte of a coordinate
  function automatic logic [7:0] coord_lo(input coord_t c);
    logic [15:0] w;
    w = 16'(c);
    return w[7:0];
  endfunction

endpackage

// ===== sv/lwbp_front.sv =====
// Front end: accepts input items, walks the bitmap counters, builds jobs.
// Depends on lwbp_pkg.
module lwbp_front import lwbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [8:0] origin_x,
  input  logic [8:0] origin_y,
  input  logic [15:0] value,
  output logic       push,
  output job_t       job
);

  logic [9:0] pixel_column, pixel_column_next;
  logic [9:0] row_number, row_number_next;
  logic [7:0] byte_in_row, byte_in_row_next;
  logic       bitmap_done, bitmap_done_next;

  logic [2:0] k0;
  logic [3:0] avail;
  logic [9:0] remaining;
  logic [3:0] npix;
  logic [4:0] two_npix_m1;
  logic [7:0] bir_inc;
  logic [9:0] row_inc;

  // Pixels this bitmap byte yields
  always_comb begin
    k0        = (byte_in_row == 8'd0) ? cfg.first_bit_offset : 3'd0;
    avail     = 4'd8 - {1'b0, k0};
    remaining = (pixel_column < cfg.rect_width) ? (cfg.rect_width - pixel_column) : 10'd0;
    npix      = (remaining < {6'd0, avail}) ? remaining[3:0] : avail;
    two_npix_m1 = {npix, 1'b0} - 5'd1;
    bir_inc   = byte_in_row + 8'd1;
    row_inc   = row_number + 10'd1;
  end

  // Job build and counter update
  always_comb begin
    pixel_column_next = pixel_column;
    row_number_next   = row_number;
    byte_in_row_next  = byte_in_row;
    bitmap_done_next  = bitmap_done;
    push              = 1'b0;

    job.kind      = JOB_PIXEL;
    job.xs        = coord_start(origin_x);
    job.xe        = coord_end(origin_x, cfg.rect_width);
    job.ys        = coord_start(origin_y);
    job.ye        = coord_end(origin_y, cfg.rect_height);
    job.value     = value;
    job.first_bit = k0;
    job.last_step = PIXEL_LAST_STEP;

    case (command)
      CMD_BEGIN_WINDOW: begin
        job.kind          = JOB_WINDOW;
        job.last_step     = WINDOW_LAST_STEP;
        push              = accept;
        pixel_column_next = 10'd0;
        row_number_next   = 10'd0;
        byte_in_row_next  = 8'd0;
        bitmap_done_next  = (cfg.rect_height == 10'd0);
      end
      CMD_BITMAP_BYTE: begin
        job.kind      = JOB_BITMAP;
        job.last_step = two_npix_m1[3:0];
        if (!bitmap_done) begin
          push              = accept && (npix != 4'd0);
          pixel_column_next = pixel_column + {6'd0, npix};
          byte_in_row_next  = bir_inc;
          // End of row: stride reached, or the byte count wrapped
          if (bir_inc >= cfg.row_stride_bytes || bir_inc == 8'd0) begin
            byte_in_row_next  = 8'd0;
            pixel_column_next = 10'd0;
            row_number_next   = row_inc;
            if (row_inc >= cfg.rect_height) begin
              bitmap_done_next = 1'b1;
            end
          end
        end
      end
      CMD_DIRECT_PIXEL: begin
        job.kind = JOB_PIXEL;
        push     = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Bitmap walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= 10'd0;
      row_number   <= 10'd0;
      byte_in_row  <= 8'd0;
      bitmap_done  <= 1'b1;
    end else if (accept) begin
      pixel_column <= pixel_column_next;
      row_number   <= row_number_next;
      byte_in_row  <= byte_in_row_next;
      bitmap_done  <= bitmap_done_next;
    end
  end

endmodule

// ===== sv/lwbp_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on lwbp_pkg.
module lwbp_queue import lwbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.not_empty = (count != '0);
  assign status.not_full  = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign head             = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/lwbp_back.sv =====
// Back end: steps through each job and sends one byte per cycle while jobs are queued and byte_ready is high.
// Depends on lwbp_pkg and the assertion macro header.
`include "lcd_window_and_bitmap_pixel_writer_top_assert.svh"

module lwbp_back import lwbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  job_t       head,
  input  q_status_t  status,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  job_t        job;
  logic        busy;
  logic [3:0]  step;
  logic        advance;
  logic        at_last;
  logic [7:0]  cur_byte;
  logic        cur_data;
  logic [2:0]  bit_pos;
  logic        pix_bit;
  logic [15:0] color;

  assign advance = busy && (!byte_valid || byte_ready);
  assign at_last = (step == job.last_step);
  assign pop     = status.not_empty && (!busy || (advance && at_last));

  // Byte for the current step
  always_comb begin
    bit_pos  = job.first_bit + step[3:1];
    pix_bit  = job.value[3'd7 - bit_pos];
    color    = pix_bit ? cfg.color_for_one : cfg.color_for_zero;
    cur_byte = 8'd0;
    cur_data = 1'b1;
    case (job.kind)
      JOB_WINDOW: begin
        case (step)
          4'd0:    begin cur_byte = LCD_COLUMN_SET;   cur_data = 1'b0; end
          4'd1:    cur_byte = coord_hi(job.xs);
          4'd2:    cur_byte = coord_lo(job.xs);
          4'd3:    cur_byte = coord_hi(job.xe);
          4'd4:    cur_byte = coord_lo(job.xe);
          4'd5:    begin cur_byte = LCD_ROW_SET;      cur_data = 1'b0; end
          4'd6:    cur_byte = coord_hi(job.ys);
          4'd7:    cur_byte = coord_lo(job.ys);
          4'd8:    cur_byte = coord_hi(job.ye);
          4'd9:    cur_byte = coord_lo(job.ye);
          default: begin cur_byte = LCD_MEMORY_WRITE; cur_data = 1'b0; end
        endcase
      end
      JOB_BITMAP: begin
        // Two bytes per pixel, high byte first
        cur_byte = step[0] ? color[7:0] : color[15:8];
      end
      JOB_PIXEL: begin
        cur_byte = step[0] ? job.value[7:0] : job.value[15:8];
      end
      default: begin
        cur_byte = 8'd0;
      end
    endcase
  end

  // Sequencer control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      step       <= 4'd0;
      byte_valid <= 1'b0;
    end else begin
      if (advance) begin
        byte_valid <= 1'b1;
        if (at_last) begin
          busy <= status.not_empty;
          step <= 4'd0;
        end else begin
          step <= step + 4'd1;
        end
      end else begin
        // Output register drains on its transfer
        if (byte_ready) begin
          byte_valid <= 1'b0;
        end
        if (!busy && status.not_empty) begin
          busy <= 1'b1;
          step <= 4'd0;
        end
      end
    end
  end

  // Job and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (advance) begin
      out_byte <= cur_byte;
      is_data  <= cur_data;
      last     <= at_last;
    end
  end

  `LWBP_ASSERT_IMPLIES(a_step_in_range, busy, step <= job.last_step, "step past end of job")
  `LWBP_ASSERT_IMPLIES(a_bitmap_job_shape, busy && job.kind == JOB_BITMAP,
    job.last_step[0] && ({1'b0, job.first_bit} + {1'b0, job.last_step[3:1]} <= 4'd7),
    "bitmap job reaches past bit 0")
  `LWBP_ASSERT_IMPLIES(a_command_bytes, byte_valid && !is_data,
    out_byte == LCD_COLUMN_SET || out_byte == LCD_ROW_SET || out_byte == LCD_MEMORY_WRITE,
    "unexpected command byte")

endmodule

// ===== sv/lcd_window_and_bitmap_pixel_writer_top.sv =====
// Top level of the LCD window and bitmap pixel writer: registers and wiring.
// Depends on lwbp_pkg, lwbp_front, lwbp_queue and lwbp_back.

// Turns window, bitmap-byte and direct-pixel items into the byte stream for a
// display controller's serial port, one byte per clock while jobs are queued
// and byte_ready is high, with is_data marking parameter and pixel bytes and
// last marking each item's final byte. A begin window item gives 11 bytes, a
// bitmap byte up to 16 (two per pixel), a direct pixel 2, and padding or
// out-of-window bitmap bytes none. The front end takes a new item every cycle
// while its four-entry job queue has room; the byte sequencer runs from one
// job into the next without a pause and so sets the sustained item rate.
// Registers sit at byte address 4*index and should be written only while the
// block is idle.
module lcd_window_and_bitmap_pixel_writer_top import lwbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input items
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [1:0]  command,
  input  logic [8:0]  origin_x,
  input  logic [8:0]  origin_y,
  input  logic [15:0] value,
  // Output bytes
  output logic        byte_valid,
  input  logic        byte_ready,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        last
);

  cfg_t      cfg;
  logic      cfg_write;
  logic [2:0] reg_index;
  logic      accept;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t status;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_width       <= 10'd1;
      cfg.rect_height      <= 10'd1;
      cfg.row_stride_bytes <= 8'd1;
      cfg.first_bit_offset <= 3'd0;
      cfg.color_for_zero   <= 16'h0000;
      cfg.color_for_one    <= 16'hFFFF;
    end else if (cfg_write) begin
      case (reg_index)
        REG_RECT_WIDTH:  cfg.rect_width       <= pwdata[9:0];
        REG_RECT_HEIGHT: cfg.rect_height      <= pwdata[9:0];
        REG_ROW_STRIDE:  cfg.row_stride_bytes <= pwdata[7:0];
        REG_FIRST_BIT:   cfg.first_bit_offset <= pwdata[2:0];
        REG_COLOR_ZERO:  cfg.color_for_zero   <= pwdata[15:0];
        REG_COLOR_ONE:   cfg.color_for_one    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_index)
      REG_RECT_WIDTH:  prdata = {22'd0, cfg.rect_width};
      REG_RECT_HEIGHT: prdata = {22'd0, cfg.rect_height};
      REG_ROW_STRIDE:  prdata = {24'd0, cfg.row_stride_bytes};
      REG_FIRST_BIT:   prdata = {29'd0, cfg.first_bit_offset};
      REG_COLOR_ZERO:  prdata = {16'd0, cfg.color_for_zero};
      REG_COLOR_ONE:   prdata = {16'd0, cfg.color_for_one};
      default:         prdata = 32'd0;
    endcase
  end

  assign cmd_ready = status.not_full;
  assign accept    = cmd_valid && cmd_ready;

  lwbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .command  (command),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .value    (value),
    .push     (push),
    .job      (push_job)
  );

  lwbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  lwbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .is_data    (is_data),
    .last       (last)
  );

endmodule
